// ----- rtl/ezvd_pkg.sv -----
// shared constants, types and controller states of the energy and zero crossing detector
// no dependencies; used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps

package ezvd_pkg;

    localparam int MAX_FRAME_LEN = 4096;
    localparam int SAMPLE_BITS   = 16;

    localparam int SQ_W     = 2 * SAMPLE_BITS;
    localparam int SUM_W    = 43;
    localparam int ENERGY_W = 31;
    localparam int CROSS_W  = 12;
    localparam int COUNT_W  = $clog2(MAX_FRAME_LEN + 2);
    localparam int FRAMES_W = 8;
    localparam int FACTOR_W = 8;
    localparam int RATE_W   = 16;
    localparam int THR_W    = ENERGY_W + FACTOR_W;
    localparam int RATER_W  = RATE_W + COUNT_W;
    localparam int RATEL_W  = CROSS_W + 16;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 31;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_FRAME_LEN + 1);
    localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(MAX_FRAME_LEN);
    localparam logic [CROSS_W-1:0] CROSS_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_FRAMES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_FACTOR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_FLOOR       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_LIMIT     = 8'd3;

    localparam logic [FRAMES_W-1:0] RST_LEARNING_FRAMES = 8'd10;
    localparam logic [FACTOR_W-1:0] RST_ENERGY_FACTOR   = 8'd16;
    localparam logic [ENERGY_W-1:0] RST_ABS_FLOOR       = 31'd11;
    localparam logic [RATE_W-1:0]   RST_CROSS_LIMIT     = 16'd29491;

    typedef enum logic [1:0] {
        S_ACCUM,
        S_DIVIDE,
        S_MULT,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic accept;
        logic frame_end;
        logic div_step;
        logic mult_en;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- rtl/ezvd_in_if.sv -----
// sample channel: valid, ready and one audio sample with its end of frame flag
// depends on ezvd_pkg for the sample width
`timescale 1ns / 1ps

interface ezvd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ezvd_pkg::SAMPLE_BITS-1:0] sample;
    logic                                 last_in_frame;

    modport source (output valid, output sample, output last_in_frame, input ready);
    modport sink   (input valid, input sample, input last_in_frame, output ready);
endinterface

// ----- rtl/ezvd_out_if.sv -----
// frame result channel: valid, ready and the per frame decision fields
// depends on ezvd_pkg for the field widths
`timescale 1ns / 1ps

interface ezvd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            voiced;
    logic [ezvd_pkg::ENERGY_W-1:0]   frame_energy;
    logic [ezvd_pkg::CROSS_W-1:0]    zero_crossings;
    logic                            learning;
    logic                            frame_too_long;

    modport source (output valid, output voiced, output frame_energy,
                    output zero_crossings, output learning, output frame_too_long,
                    input ready);
    modport sink   (input valid, input voiced, input frame_energy,
                    input zero_crossings, input learning, input frame_too_long,
                    output ready);
endinterface

// ----- rtl/ezvd_ctrl.sv -----
// controller: sequences accumulate, bit serial divide, threshold multiply and decision
// depends on ezvd_pkg for the state enum and the command and status structs
`timescale 1ns / 1ps

module ezvd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    output logic                 o_in_ready,
    input  ezvd_pkg::t_dp_status i_status,
    output ezvd_pkg::t_dp_cmd    o_cmd
);

    ezvd_pkg::t_state r_state;
    ezvd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ezvd_pkg::S_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ezvd_pkg::S_ACCUM: begin
                if (i_in_valid && i_in_last) begin
                    n_state = ezvd_pkg::S_DIVIDE;
                end
            end
            ezvd_pkg::S_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = ezvd_pkg::S_MULT;
                end
            end
            ezvd_pkg::S_MULT: begin
                n_state = ezvd_pkg::S_DECIDE;
            end
            ezvd_pkg::S_DECIDE: begin
                if (!i_status.out_busy) begin
                    n_state = ezvd_pkg::S_ACCUM;
                end
            end
            default: n_state = ezvd_pkg::S_ACCUM;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ezvd_pkg::S_ACCUM: begin
                o_in_ready      = 1'b1;
                o_cmd.accept    = i_in_valid;
                o_cmd.frame_end = i_in_valid && i_in_last;
            end
            ezvd_pkg::S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ezvd_pkg::S_MULT: begin
                o_cmd.mult_en = 1'b1;
            end
            ezvd_pkg::S_DECIDE: begin
                // hold the decision until the output register can take a new word
                o_cmd.finish = !i_status.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/ezvd_dp.sv -----
// datapath: configuration registers, frame accumulators, divider, noise floor and output word
// depends on ezvd_pkg; driven by ezvd_ctrl through the command and status structs
`timescale 1ns / 1ps

module ezvd_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ezvd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ezvd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [ezvd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  ezvd_pkg::t_dp_cmd                      i_cmd,
    output ezvd_pkg::t_dp_status                   o_status,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_voiced,
    output logic [ezvd_pkg::ENERGY_W-1:0]          o_frame_energy,
    output logic [ezvd_pkg::CROSS_W-1:0]           o_zero_crossings,
    output logic                                   o_learning,
    output logic                                   o_frame_too_long
);

    // configuration
    logic [ezvd_pkg::FRAMES_W-1:0] r_learn_frames;
    logic [ezvd_pkg::FACTOR_W-1:0] r_factor;
    logic [ezvd_pkg::ENERGY_W-1:0] r_abs_floor;
    logic [ezvd_pkg::RATE_W-1:0]   r_cross_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_frames <= ezvd_pkg::RST_LEARNING_FRAMES;
            r_factor       <= ezvd_pkg::RST_ENERGY_FACTOR;
            r_abs_floor    <= ezvd_pkg::RST_ABS_FLOOR;
            r_cross_limit  <= ezvd_pkg::RST_CROSS_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ezvd_pkg::REG_LEARNING_FRAMES:
                    r_learn_frames <= i_cfg_data[ezvd_pkg::FRAMES_W-1:0];
                ezvd_pkg::REG_ENERGY_FACTOR:
                    r_factor <= i_cfg_data[ezvd_pkg::FACTOR_W-1:0];
                ezvd_pkg::REG_ABS_FLOOR:
                    r_abs_floor <= i_cfg_data[ezvd_pkg::ENERGY_W-1:0];
                ezvd_pkg::REG_CROSS_LIMIT:
                    r_cross_limit <= i_cfg_data[ezvd_pkg::RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // per sample accumulation
    logic [ezvd_pkg::SUM_W-1:0]   r_sum;
    logic [ezvd_pkg::CROSS_W-1:0] r_cross;
    logic [ezvd_pkg::COUNT_W-1:0] r_count;
    logic                         r_prev_nonneg;

    logic [ezvd_pkg::SAMPLE_BITS-1:0] sample_u;
    logic                             negative;
    logic [ezvd_pkg::SAMPLE_BITS-1:0] mag;
    logic [ezvd_pkg::SQ_W-1:0]        sq;
    logic [ezvd_pkg::SUM_W:0]         sum_wide;
    logic [ezvd_pkg::SUM_W-1:0]       n_sum;
    logic [ezvd_pkg::CROSS_W-1:0]     n_cross;
    logic [ezvd_pkg::COUNT_W-1:0]     n_count;

    always_comb begin
        sample_u = $unsigned(i_sample);
        negative = sample_u[ezvd_pkg::SAMPLE_BITS-1];
        mag      = negative ? ezvd_pkg::SAMPLE_BITS'(~sample_u + 1'b1) : sample_u;
        sq       = ezvd_pkg::SQ_W'(mag) * ezvd_pkg::SQ_W'(mag);
        sum_wide = {1'b0, r_sum} + (ezvd_pkg::SUM_W + 1)'(sq);
        n_sum    = sum_wide[ezvd_pkg::SUM_W] ? ezvd_pkg::SUM_MAX
                                             : sum_wide[ezvd_pkg::SUM_W-1:0];
        n_cross  = r_cross;
        // a crossing needs a previous sample in this frame
        if (r_count != '0 && (!negative) != r_prev_nonneg && r_cross != ezvd_pkg::CROSS_MAX) begin
            n_cross = r_cross + 1'b1;
        end
        n_count = (r_count < ezvd_pkg::COUNT_MAX) ? r_count + 1'b1 : r_count;
    end

    // frame end capture and restoring divider, one quotient bit a cycle
    logic [ezvd_pkg::SUM_W-1:0]     r_quot;
    logic [ezvd_pkg::COUNT_W-1:0]   r_rem;
    logic [ezvd_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [ezvd_pkg::COUNT_W-1:0]   r_f_count;
    logic [ezvd_pkg::CROSS_W-1:0]   r_f_cross;

    logic [ezvd_pkg::COUNT_W:0] div_trial;
    logic [ezvd_pkg::COUNT_W:0] div_diff;
    logic                       div_bit;

    always_comb begin
        div_trial = {r_rem, r_quot[ezvd_pkg::SUM_W-1]};
        div_diff  = div_trial - {1'b0, r_f_count};
        div_bit   = div_trial >= {1'b0, r_f_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum         <= '0;
            r_cross       <= '0;
            r_count       <= '0;
            r_prev_nonneg <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_cmd.frame_end) begin
                r_sum         <= '0;
                r_cross       <= '0;
                r_count       <= '0;
                r_prev_nonneg <= 1'b0;
            end else begin
                r_sum         <= n_sum;
                r_cross       <= n_cross;
                r_count       <= n_count;
                r_prev_nonneg <= !negative;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_end) begin
            r_quot    <= n_sum;
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_f_count <= n_count;
            r_f_cross <= n_cross;
        end else if (i_cmd.div_step) begin
            r_quot    <= {r_quot[ezvd_pkg::SUM_W-2:0], div_bit};
            r_rem     <= div_bit ? div_diff[ezvd_pkg::COUNT_W-1:0]
                                 : div_trial[ezvd_pkg::COUNT_W-1:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // threshold products, registered before the compare
    logic [ezvd_pkg::ENERGY_W-1:0] r_energy;
    logic [ezvd_pkg::THR_W-1:0]    r_thr;
    logic [ezvd_pkg::RATER_W-1:0]  r_rate_r;
    logic [ezvd_pkg::ENERGY_W-1:0] r_floor;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult_en) begin
            r_energy <= (r_quot[ezvd_pkg::SUM_W-1:ezvd_pkg::ENERGY_W] != '0)
                      ? ezvd_pkg::ENERGY_MAX : r_quot[ezvd_pkg::ENERGY_W-1:0];
            r_thr    <= ezvd_pkg::THR_W'(r_floor) * ezvd_pkg::THR_W'(r_factor);
            r_rate_r <= ezvd_pkg::RATER_W'(r_cross_limit) * ezvd_pkg::RATER_W'(r_f_count);
        end
    end

    // decision
    logic [ezvd_pkg::FRAMES_W-1:0] r_frames_seen;
    logic                          too_long;
    logic                          learning;
    logic [ezvd_pkg::THR_W-1:0]    thr_eff;
    logic [ezvd_pkg::RATEL_W-1:0]  rate_l;
    logic                          speech;
    logic                          floor_upd;
    logic                          frames_inc;

    always_comb begin
        too_long = r_f_count > ezvd_pkg::FRAME_LIMIT;
        learning = r_frames_seen < r_learn_frames;
        thr_eff  = (r_thr < ezvd_pkg::THR_W'(r_abs_floor)) ? ezvd_pkg::THR_W'(r_abs_floor)
                                                           : r_thr;
        rate_l   = {r_f_cross, 16'b0};
        speech   = !too_long && !learning
                && (ezvd_pkg::THR_W'(r_energy) > thr_eff)
                && (ezvd_pkg::RATER_W'(rate_l) < r_rate_r);
        floor_upd  = !too_long && !speech
                  && (r_frames_seen == '0 || r_energy < r_floor);
        frames_inc = !too_long && (r_frames_seen == '0 || learning)
                  && r_frames_seen != ezvd_pkg::FRAMES_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor       <= '0;
            r_frames_seen <= '0;
        end else if (i_cmd.finish) begin
            if (floor_upd) begin
                r_floor <= r_energy;
            end
            if (frames_inc) begin
                r_frames_seen <= r_frames_seen + 1'b1;
            end
        end
    end

    // output register
    logic                          r_out_valid;
    logic                          r_res_voiced;
    logic [ezvd_pkg::ENERGY_W-1:0] r_res_energy;
    logic [ezvd_pkg::CROSS_W-1:0]  r_res_cross;
    logic                          r_res_learning;
    logic                          r_res_too_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_voiced   <= speech;
            r_res_energy   <= too_long ? '0 : r_energy;
            r_res_cross    <= r_f_cross;
            r_res_learning <= learning;
            r_res_too_long <= too_long;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_voiced          = r_res_voiced;
    assign o_frame_energy    = r_res_energy;
    assign o_zero_crossings  = r_res_cross;
    assign o_learning        = r_res_learning;
    assign o_frame_too_long  = r_res_too_long;
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_status.div_done = r_div_cnt == ezvd_pkg::DIV_LAST;

endmodule

// ----- rtl/energy_zcr_voice_detector_core.sv -----
// Energy and zero crossing voice activity detector. Within a frame one sample word is
// taken every clock cycle; its square and sign change are accumulated at once. The word
// flagged last in frame starts the frame decision: a restoring divider forms the mean
// square one quotient bit per cycle, then the threshold products are registered and the
// decision follows; no sample is taken until the decision is done. The result word sits
// in an output register, and the next frame streams in while it waits; a decision waits
// only if the previous result is still untaken.
// Depends on ezvd_pkg, ezvd_in_if, ezvd_out_if, ezvd_ctrl and ezvd_dp.
`timescale 1ns / 1ps

module energy_zcr_voice_detector_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ezvd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ezvd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ezvd_in_if.sink                         i_in,
    ezvd_out_if.source                      o_out
);

    ezvd_pkg::t_dp_cmd    cmd;
    ezvd_pkg::t_dp_status status;

    ezvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_in_frame),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ezvd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_in.sample),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_voiced         (o_out.voiced),
        .o_frame_energy   (o_out.frame_energy),
        .o_zero_crossings (o_out.zero_crossings),
        .o_learning       (o_out.learning),
        .o_frame_too_long (o_out.frame_too_long)
    );

endmodule
